// File: hw/rtl/assert_macros.svh
// Concurrent check on i_clk, masked while i_rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define GNMS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Concurrent check on i_clk, active during reset as well
`define GNMS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// File: hw/rtl/gnms_pkg.sv
package gnms_pkg;

    localparam int CELL_W      = 32;
    localparam int NUM_CELLS   = 4;
    localparam int SUM_W       = CELL_W + 2;
    localparam int SCORE_W     = 48;
    localparam int IN_TDATA_W  = NUM_CELLS * CELL_W;
    localparam int OUT_TDATA_W = SCORE_W;

    typedef logic signed [CELL_W-1:0]  t_cell;
    typedef logic signed [SUM_W-1:0]   t_sum;
    typedef logic signed [SCORE_W-1:0] t_score;

endpackage

// File: hw/rtl/gnms_max_tree.sv
module gnms_max_tree #(
    parameter int N = 16
) (
    input  gnms_pkg::t_score i_val [N],
    output gnms_pkg::t_score o_max
);

    gnms_pkg::t_score w_node [2*N-1];

    for (genvar i = 0; i < N; i++) begin : g_leaf
        assign w_node[N-1+i] = i_val[i];
    end

    for (genvar i = 0; i < N-1; i++) begin : g_node
        assign w_node[i] = (w_node[2*i+1] > w_node[2*i+2]) ? w_node[2*i+1] : w_node[2*i+2];
    end

    assign o_max = w_node[0];

endmodule

// File: hw/rtl/gnms_dp_update.sv
module gnms_dp_update #(
    parameter int ROWS = 4
) (
    input  gnms_pkg::t_cell  i_cell  [gnms_pkg::NUM_CELLS],
    input  logic             i_first,
    input  gnms_pkg::t_score i_score [1 << ROWS],
    output gnms_pkg::t_score o_next  [1 << ROWS]
);

    localparam int NMASK = 1 << ROWS;
    localparam int SUM_W = gnms_pkg::SUM_W;
    localparam int SCORE_W = gnms_pkg::SCORE_W;

    for (genvar b = 0; b < NMASK; b++) begin : g_mask
        localparam int unsigned MASK = b;

        gnms_pkg::t_score w_cand [NMASK];
        gnms_pkg::t_score w_tree_max;
        gnms_pkg::t_score w_best;
        gnms_pkg::t_sum   w_sum;
        logic signed [SCORE_W:0] w_total;

        for (genvar p = 0; p < NMASK; p++) begin : g_cand
            localparam int unsigned PMASK = p;
            localparam bit COMPAT = ((PMASK & MASK) == 0) && (((PMASK << 1) & MASK) == 0);
            assign w_cand[p] = (COMPAT && !i_first) ? i_score[p] : '0;
        end

        gnms_max_tree #(
            .N (NMASK)
        ) u_best (
            .i_val (w_cand),
            .o_max (w_tree_max)
        );

        always_comb begin
            w_sum = '0;
            for (int r = 0; r < gnms_pkg::NUM_CELLS; r++) begin
                if ((r < ROWS) && (((MASK >> r) & 1) != 0)) begin
                    w_sum = w_sum + SUM_W'(i_cell[r]);
                end
            end
        end

        assign w_best  = w_tree_max[SCORE_W-1] ? '0 : w_tree_max;
        assign w_total = {{(SCORE_W + 1 - SUM_W){w_sum[SUM_W-1]}}, w_sum}
                       + {w_best[SCORE_W-1], w_best};

        // saturate to the signed score range
        always_comb begin
            if (w_total[SCORE_W] != w_total[SCORE_W-1]) begin
                o_next[b] = {w_total[SCORE_W], {(SCORE_W-1){~w_total[SCORE_W]}}};
            end else begin
                o_next[b] = w_total[SCORE_W-1:0];
            end
        end
    end

endmodule

// File: hw/rtl/grid_nonadjacent_max_sum_dp_core.sv
// channel  dir  tdata                              tuser     tlast
// s_axis   in   cell_row0..cell_row3 (32b each)    is_first  is_last
// m_axis   out  best_total (48b)                   -         -
//
// One diagonal per cycle while the score stage can advance; the mask scores load
// from the input register as the score stage advances (one predecessor max tree plus
// add per mask); a last diagonal's best_total then goes to the m_axis output register.
// Synchronous active-low reset clears all mask scores and the valid flags.
// A stalled m_axis holds the result; requests flow on until a second last diagonal waits
// in the score stage and one more fills the input register, then s_axis_tready drops.
`include "assert_macros.svh"

module grid_nonadjacent_max_sum_dp_core #(
    parameter int ROWS = 4
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // cell_row0 [31:0], cell_row1 [63:32], cell_row2 [95:64], cell_row3 [127:96]
    input  logic [gnms_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    // is_first
    input  logic                                 s_axis_tuser,
    input  logic                                 s_axis_tlast,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // best_total [47:0]
    output logic [gnms_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);

    localparam int NMASK = 1 << ROWS;
    localparam int CELL_W = gnms_pkg::CELL_W;
    localparam int SCORE_W = gnms_pkg::SCORE_W;

    logic             r_in_valid;
    gnms_pkg::t_cell  r_cell [gnms_pkg::NUM_CELLS];
    logic             r_in_first;
    logic             r_in_last;
    gnms_pkg::t_score r_score [NMASK];
    gnms_pkg::t_score w_next  [NMASK];
    logic             r_emit_valid;
    logic             r_out_valid;
    gnms_pkg::t_score r_out_data;
    gnms_pkg::t_score w_top;

    logic w_out_free;
    logic w_s1_free;
    logic w_s1_adv;
    logic w_in_ready;

    assign w_out_free = !r_out_valid || m_axis_tready;
    assign w_s1_free  = !r_emit_valid || w_out_free;
    assign w_s1_adv   = r_in_valid && w_s1_free;
    assign w_in_ready = !r_in_valid || w_s1_free;

    assign s_axis_tready = w_in_ready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_ready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_ready && s_axis_tvalid) begin
            for (int r = 0; r < gnms_pkg::NUM_CELLS; r++) begin
                r_cell[r] <= s_axis_tdata[r*CELL_W +: CELL_W];
            end
            r_in_first <= s_axis_tuser;
            r_in_last  <= s_axis_tlast;
        end
    end

    gnms_dp_update #(
        .ROWS (ROWS)
    ) u_update (
        .i_cell  (r_cell),
        .i_first (r_in_first),
        .i_score (r_score),
        .o_next  (w_next)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int b = 0; b < NMASK; b++) begin
                r_score[b] <= '0;
            end
        end else if (w_s1_adv) begin
            r_score <= w_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_emit_valid <= 1'b0;
        end else if (w_s1_free) begin
            r_emit_valid <= r_in_valid && r_in_last;
        end
    end

    gnms_max_tree #(
        .N (NMASK)
    ) u_top (
        .i_val (r_score),
        .o_max (w_top)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= r_emit_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free && r_emit_valid) begin
            r_out_data <= w_top;
        end
    end

    `GNMS_ASSERT(a_mask0_nonneg, (!r_score[0][SCORE_W-1]), "empty-mask score went negative")
    `GNMS_ASSERT(a_score_hold, ((r_emit_valid && !w_out_free) |=> $stable(r_score[0])), "scores moved under a pending result")
    `GNMS_ASSERT(a_out_from_emit, ($rose(r_out_valid) |-> $past(r_emit_valid)), "result without a last diagonal")

endmodule
